>>> src/efrb_pkg.sv
// Shared constants, types and helpers for the feedback echo ring buffer.
`timescale 1ns / 1ps

package efrb_pkg;

  // Ring geometry; the depth must be a power of two
  localparam int RING_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_MSEC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PCT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_PCT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  localparam int ECHO_MSEC_W = 11;
  localparam int PCT_W       = 7;
  localparam int RATE_W      = 18;
  localparam int CHAN_W      = 2;

  localparam logic [ECHO_MSEC_W-1:0] ECHO_MSEC_LO   = 11'd10;
  localparam logic [ECHO_MSEC_W-1:0] ECHO_MSEC_HI   = 11'd1500;
  localparam logic [ECHO_MSEC_W-1:0] ECHO_MSEC_RST  = 11'd300;
  localparam logic [PCT_W-1:0]       DECAY_PCT_MAX  = 7'd95;
  localparam logic [PCT_W-1:0]       DECAY_PCT_RST  = 7'd50;
  localparam logic [PCT_W-1:0]       WET_PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0]       WET_PCT_RST    = 7'd100;
  localparam logic [RATE_W-1:0]      FRAME_RATE_LO  = 18'd8000;
  localparam logic [RATE_W-1:0]      FRAME_RATE_HI  = 18'd192000;
  localparam logic [RATE_W-1:0]      RATE_RST       = 18'd48000;
  localparam logic [CHAN_W-1:0]      CHAN_MIN       = 2'd1;
  localparam logic [CHAN_W-1:0]      CHAN_MAX       = 2'd2;
  localparam logic [CHAN_W-1:0]      CHAN_RST       = 2'd2;

  // echo time * rate * channels fits in 30 bits; /1000 is >>3 then /125
  localparam int DIV_W         = 30;
  localparam int DIV_PRE_SHIFT = 3;
  // ceil(2^34/125): exact floor(n/125) for every n below 2^27
  localparam int DIV125_RECIP  = 137438954;
  localparam int DIV125_SHIFT  = 34;
  localparam int QPROD_W       = DIV_W - DIV_PRE_SHIFT + 28;

  // Q7 gains
  localparam int GAIN_W    = 8;
  localparam int Q7_ONE    = 128;
  // ceil(2^20/100): exact floor(n/100) for every n up to 12800
  localparam int GAIN_RECIP = 10486;

  localparam logic FUNC_PLAYBACK = 1'b0;
  localparam logic FUNC_CAPTURE  = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Derived settings handed from the config block to the datapath
  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] delay;
    logic [GAIN_W-1:0] fb_gain;
    logic [GAIN_W-1:0] wet_fp;
    logic [GAIN_W-1:0] dry_fp;
  } efrb_gain_t;

  // floor(pct * 128 / 100) by reciprocal multiply
  function automatic logic [GAIN_W-1:0] gain_q7(input logic [PCT_W-1:0] pct);
    logic [27:0] prod;
    prod = 28'({pct, 7'b0}) * 28'(GAIN_RECIP);
    return prod[27:20];
  endfunction

endpackage

>>> src/efrb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module efrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/efrb_cfg.sv
// Configuration registers and derivation of delay in samples and Q7 gains.
`timescale 1ns / 1ps

module efrb_cfg import efrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output efrb_gain_t            gain_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_CLAMP} state_t;

  state_t                 state_r;
  logic [ECHO_MSEC_W-1:0] echo_msec_r;
  logic [PCT_W-1:0]       decay_pct_r;
  logic [PCT_W-1:0]       wet_pct_r;
  logic [RATE_W-1:0]      rate_r;
  logic [CHAN_W-1:0]      chan_r;

  logic [DIV_W-1:0]       div_r;
  logic [ADDR_W-1:0]      delay_r;
  logic [GAIN_W-1:0]      fb_gain_r;
  logic [GAIN_W-1:0]      wet_fp_r;

  logic [ECHO_MSEC_W-1:0] wd_delay;
  logic [PCT_W-1:0]       wd_pct;
  logic [RATE_W-1:0]      wd_rate;
  logic [CHAN_W-1:0]      wd_chan;
  logic [DIV_W-2:0]       prod;
  logic [QPROD_W-1:0]     qprod;

  assign wd_delay = cfg_wdata[ECHO_MSEC_W-1:0];
  assign wd_pct   = cfg_wdata[PCT_W-1:0];
  assign wd_rate  = cfg_wdata[RATE_W-1:0];
  assign wd_chan  = cfg_wdata[CHAN_W-1:0];

  assign prod = (DIV_W-1)'(echo_msec_r) * (DIV_W-1)'(rate_r);

  // n / 1000 = (n >> 3) / 125, the second step by reciprocal multiply
  assign qprod = QPROD_W'(div_r[DIV_W-1:DIV_PRE_SHIFT]) * QPROD_W'(DIV125_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_MUL;
      echo_msec_r <= ECHO_MSEC_RST;
      decay_pct_r <= DECAY_PCT_RST;
      wet_pct_r   <= WET_PCT_RST;
      rate_r      <= RATE_RST;
      chan_r      <= CHAN_RST;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_ECHO_MSEC: begin
            echo_msec_r <= (wd_delay < ECHO_MSEC_LO) ? ECHO_MSEC_LO :
                           (wd_delay > ECHO_MSEC_HI) ? ECHO_MSEC_HI : wd_delay;
          end
          REG_DECAY_PCT: begin
            decay_pct_r <= (wd_pct > DECAY_PCT_MAX) ? DECAY_PCT_MAX : wd_pct;
          end
          REG_WET_PCT: begin
            wet_pct_r <= (wd_pct > WET_PCT_MAX) ? WET_PCT_MAX : wd_pct;
          end
          REG_SAMPLE_RATE: begin
            rate_r <= (wd_rate < FRAME_RATE_LO) ? FRAME_RATE_LO :
                      (wd_rate > FRAME_RATE_HI) ? FRAME_RATE_HI : wd_rate;
          end
          REG_CHANNEL_COUNT: begin
            chan_r <= (wd_chan < CHAN_MIN) ? CHAN_MIN :
                      (wd_chan > CHAN_MAX) ? CHAN_MAX : wd_chan;
          end
          default: ;
        endcase
      end

      // any write restarts the derivation with the new values
      if (cfg_wr_en) begin
        state_r <= S_MUL;
      end else begin
        unique case (state_r)
          S_IDLE: ;
          S_MUL: begin
            div_r   <= (chan_r == CHAN_MAX) ? {prod, 1'b0} : {1'b0, prod};
            state_r <= S_DIV;
          end
          S_DIV: begin
            div_r   <= DIV_W'(qprod[QPROD_W-1:DIV125_SHIFT]);
            state_r <= S_CLAMP;
          end
          S_CLAMP: begin
            delay_r   <= (div_r >= DIV_W'(RING_DEPTH)) ? ADDR_W'(RING_DEPTH - 1)
                                                        : div_r[ADDR_W-1:0];
            fb_gain_r <= gain_q7(decay_pct_r);
            wet_fp_r  <= gain_q7(wet_pct_r);
            state_r   <= S_IDLE;
          end
          default: state_r <= S_MUL;
        endcase
      end
    end
  end

  assign gain_o.busy    = (state_r != S_IDLE);
  assign gain_o.delay   = delay_r;
  assign gain_o.fb_gain = fb_gain_r;
  assign gain_o.wet_fp  = wet_fp_r;
  assign gain_o.dry_fp  = GAIN_W'(Q7_ONE) - wet_fp_r;

endmodule

>>> src/feedback_echo_ring_buffer_core.sv
// Top level of the feedback echo ring buffer: ring memory, counts and mix datapath.
//
// A request occupies the core until it commits: the ring is read at acceptance,
// the feedback and dry products are formed from the registered read data, then the
// wet product is mixed, saturated, written back to the ring and loaded into the
// output register once that register is free; the next request is taken after the
// commit. The single ring memory port pair and the two dependent multiplies keep the
// core from taking a new request before it is through with the last one. A result
// waiting in the output register does not hold off the next request until that
// request reaches writeback. After reset and after every configuration write,
// in_ready stays low while a shift and a reciprocal multiply divide by 1000 to
// derive the delay in samples and the Q7 gains. Playback refuses a request when the
// ring is full, capture when it is empty; the result then carries accepted low. Ring
// entries never written since reset read as zero: the write address and a wrap flag
// tell which entries hold data, so no clearing pass is needed.
`timescale 1ns / 1ps

module feedback_echo_ring_buffer_core import efrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic [FILL_W-1:0]     out_fill_level,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_MULT, ST_COMMIT} state_t;

  efrb_gain_t gain;

  state_t            state_r;
  logic [CNT_W-1:0]  wr_cnt_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              wrapped_r;
  logic              func_r;
  sample_t           sample_r;
  logic              dvalid_r;
  logic signed [23:0] m_fb_r;
  logic signed [23:0] m_dry_r;
  logic              out_valid_r;
  logic              out_accepted_r;
  sample_t           out_sample_r;
  logic [FILL_W-1:0] out_fill_r;

  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] daddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic              in_acc;
  logic              ring_full;
  logic              ring_empty;

  sample_t            delayed;
  logic signed [23:0] m_fb_nxt;
  logic signed [23:0] m_dry_nxt;
  logic signed [17:0] wet;
  logic signed [25:0] m_wet;
  logic signed [19:0] mix;
  sample_t            mix_sat;

  logic              ok;
  logic              out_free;
  logic              commit;
  logic              ram_we;
  logic              rd_adv;
  logic [CNT_W-1:0]  wr_cnt_nxt;
  logic [CNT_W-1:0]  rd_cnt_nxt;
  logic [CNT_W-1:0]  fill_post;
  sample_t           result;

  efrb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .gain_o    (gain)
  );

  efrb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (mix_sat),
    .re    (in_acc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fill       = wr_cnt_r - rd_cnt_r;
  assign ring_full  = fill[ADDR_W];
  assign ring_empty = (fill == '0);
  assign waddr      = wr_cnt_r[ADDR_W-1:0];
  assign daddr      = waddr - gain.delay;
  assign ram_raddr  = (in_func == FUNC_CAPTURE) ? rd_cnt_r[ADDR_W-1:0] : daddr;

  assign in_ready = (state_r == ST_IDLE) && !gain.busy;
  assign in_acc   = in_valid && in_ready;

  // products from the delayed sample and the dry path
  always_comb begin
    delayed   = dvalid_r ? sample_t'(ram_rdata) : '0;
    m_fb_nxt  = {{8{delayed[SAMPLE_W-1]}}, delayed} * $signed({16'b0, gain.fb_gain});
    m_dry_nxt = {{8{sample_r[SAMPLE_W-1]}}, sample_r} * $signed({16'b0, gain.dry_fp});
  end

  // wet path, mix and saturation; dropping the low 7 bits is floor division
  always_comb begin
    wet   = {{2{sample_r[SAMPLE_W-1]}}, sample_r} + {m_fb_r[23], m_fb_r[23:7]};
    m_wet = {{8{wet[17]}}, wet} * $signed({18'b0, gain.wet_fp});
    mix   = {{3{m_dry_r[23]}}, m_dry_r[23:7]} + {m_wet[25], m_wet[25:7]};
    if (mix[19:15] != {5{mix[19]}}) begin
      mix_sat = mix[19] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      mix_sat = mix[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    ok         = (func_r == FUNC_PLAYBACK) ? !ring_full : !ring_empty;
    out_free   = !out_valid_r || out_ready;
    commit     = (state_r == ST_COMMIT) && out_free;
    ram_we     = commit && ok && (func_r == FUNC_PLAYBACK);
    rd_adv     = commit && ok && (func_r == FUNC_CAPTURE);
    wr_cnt_nxt = ram_we ? wr_cnt_r + CNT_W'(1) : wr_cnt_r;
    rd_cnt_nxt = rd_adv ? rd_cnt_r + CNT_W'(1) : rd_cnt_r;
    fill_post  = wr_cnt_nxt - rd_cnt_nxt;
    if (!ok) begin
      result = '0;
    end else if (func_r == FUNC_PLAYBACK) begin
      result = mix_sat;
    end else begin
      result = sample_t'(ram_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_cnt_r    <= '0;
      rd_cnt_r    <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            func_r   <= in_func;
            sample_r <= in_sample_in;
            // entries behind the write address, or any once the ring wrapped
            dvalid_r <= wrapped_r || (daddr < waddr);
            state_r  <= ST_MULT;
          end
        end
        ST_MULT: begin
          m_fb_r  <= m_fb_nxt;
          m_dry_r <= m_dry_nxt;
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      wr_cnt_r <= wr_cnt_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (ram_we && (waddr == '1)) begin
        wrapped_r <= 1'b1;
      end

      if (commit) begin
        out_valid_r    <= 1'b1;
        out_accepted_r <= ok;
        out_sample_r   <= result;
        out_fill_r     <= FILL_W'(32'(fill_post));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_sample_out = out_sample_r;
  assign out_fill_level = out_fill_r;

endmodule
